### rtl/tpvb_pkg.sv
// Package for the two-plane visited bitmap core.
// Holds the payload and command types, action and register codes, and geometry constants.
// No dependencies; every other file but tpvb_ram imports it.
package tpvb_pkg;

  localparam int MAX_COLS = 256;
  localparam int MAX_ROWS = 256;
  localparam int PLANE_CELLS = MAX_COLS * MAX_ROWS;

  // One memory word holds this many cell bits.
  localparam int WORD_W = 512;
  localparam int WB_W = $clog2(WORD_W);
  localparam int PLANE_WORDS = (PLANE_CELLS + WORD_W - 1) / WORD_W;
  localparam int WADDR_W = (PLANE_WORDS > 1) ? $clog2(PLANE_WORDS) : 1;
  localparam int IDX_W = WADDR_W + WB_W;
  // Both planes share one memory; the plane select is the top address bit.
  localparam int RAM_AW = WADDR_W + 1;
  localparam int RAM_DEPTH = 2 << WADDR_W;

  localparam int CFG_W = 9;
  localparam int CFG_IDX_W = 2;
  localparam int COORD_W = 9;
  localparam int CALC_W = 2 * CFG_W + 1;

  localparam logic [1:0] ACT_MARK = 2'd0;
  localparam logic [1:0] ACT_QUERY = 2'd1;
  localparam logic [1:0] ACT_ADVANCE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd1;

  localparam logic [CFG_W-1:0] COLS_RESET = 9'd256;
  localparam logic [CFG_W-1:0] ROWS_RESET = 9'd256;

  typedef struct packed {
    logic [1:0]         action;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               which_plane;
  } request_t;

  typedef struct packed {
    logic processed;
    logic out_of_range;
  } response_t;

  typedef struct packed {
    logic load;    // capture the request and work out the cell index
    logic read;    // read the addressed word and its valid flag
    logic finish;  // update the word or planes and register the result
  } ctrl_cmd_t;

endpackage

### rtl/tpvb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the bit planes of the two-plane visited bitmap core; no package dependency.
module tpvb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/tpvb_ctrl.sv
// Controller for the two-plane visited bitmap core: sequences load, read and finish.
// Depends on tpvb_pkg for the command struct.
module tpvb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output tpvb_pkg::ctrl_cmd_t cmd
);
  import tpvb_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.read = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/tpvb_dp.sv
// Datapath for the two-plane visited bitmap core: configuration, cell index, plane memory,
// per-word valid flags and the result register. Depends on tpvb_pkg and tpvb_ram.
module tpvb_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  tpvb_pkg::ctrl_cmd_t               cmd,
  input  tpvb_pkg::request_t                request,
  input  logic                              cfg_we,
  input  logic [tpvb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tpvb_pkg::CFG_W-1:0]        cfg_data,
  output logic                              done,
  output tpvb_pkg::response_t               response
);
  import tpvb_pkg::*;

  logic [CFG_W-1:0]   cols_in_use;
  logic [CFG_W-1:0]   rows_in_use;
  logic [CFG_W-1:0]   cols_lim;
  logic [CFG_W-1:0]   rows_lim;
  logic               oor_next;
  logic [CALC_W-1:0]  lin;

  logic [1:0]         action_q;
  logic               plane_q;
  logic               oor_q;
  logic [IDX_W-1:0]   idx_q;
  logic               cur_b;

  logic [RAM_DEPTH-1:0] valid;
  logic                 valid_rd_q;
  logic [RAM_AW-1:0]    raddr;
  logic [RAM_AW-1:0]    addr_q;
  logic [WORD_W-1:0]    rdata;
  logic [WORD_W-1:0]    word;
  logic [WORD_W-1:0]    wdata;
  logic [WB_W-1:0]      bit_sel;
  logic                 cell_bit;
  logic                 mark_we;
  logic                 in_grid;
  response_t            result;

  // Limits are the registers clamped to the plane geometry.
  assign cols_lim = ({23'd0, cols_in_use} > 32'(MAX_COLS)) ? CFG_W'(MAX_COLS) : cols_in_use;
  assign rows_lim = ({23'd0, rows_in_use} > 32'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : rows_in_use;

  assign oor_next = (request.col == '0) || (request.row == '0) ||
                    (request.col > cols_lim) || (request.row > rows_lim);
  assign lin = CALC_W'(request.row - 1'b1) * CALC_W'(cols_lim) +
               CALC_W'(request.col - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use <= COLS_RESET;
      rows_in_use <= ROWS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLS: cols_in_use <= cfg_data;
        REG_ROWS: rows_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_q <= request.action;
      plane_q  <= request.which_plane;
      oor_q    <= oor_next;
      idx_q    <= IDX_W'(lin);
    end
  end

  // A mark always targets the current plane; a query picks current or previous.
  assign raddr = {cur_b ^ ((action_q == ACT_QUERY) & plane_q), idx_q[IDX_W-1:WB_W]};

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      addr_q     <= raddr;
      valid_rd_q <= valid[raddr];
    end
  end

  tpvb_ram #(
    .WIDTH (WORD_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (addr_q),
    .wdata (wdata),
    .re    (cmd.read),
    .raddr (raddr),
    .rdata (rdata)
  );

  // A word whose flag is clear has not been written since its plane was cleared.
  assign word     = valid_rd_q ? rdata : '1;
  assign bit_sel  = idx_q[WB_W-1:0];
  assign cell_bit = word[bit_sel];
  assign in_grid  = !oor_q;
  assign mark_we  = cmd.finish && (action_q == ACT_MARK) && in_grid;

  always_comb begin
    wdata = word;
    wdata[bit_sel] = 1'b0;
  end

  always_comb begin
    result = '0;
    case (action_q)
      ACT_MARK: begin
        result.out_of_range = oor_q;
      end
      ACT_QUERY: begin
        result.out_of_range = oor_q;
        result.processed    = in_grid & ~cell_bit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      cur_b <= 1'b0;
    end else if (cmd.finish) begin
      if (mark_we) begin
        valid[addr_q] <= 1'b1;
      end
      if (action_q == ACT_ADVANCE) begin
        cur_b <= ~cur_b;
        // The old previous plane becomes current and reads as unprocessed.
        for (int w = 0; w < (1 << WADDR_W); w++) begin
          valid[{~cur_b, WADDR_W'(w)}] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      response <= result;
    end
  end

endmodule

### rtl/two_plane_visited_bitmap_core.sv
// Top level of the two-plane visited bitmap core: controller plus datapath.
// Depends on tpvb_pkg, tpvb_ctrl, tpvb_dp and tpvb_ram.
//
// A request is taken when start is high and busy is low. Every request (mark, query,
// advance or the unused code) gives one response, shown with done high for one cycle;
// busy drops in that same cycle, so a request is taken only once the last is answered.
// The steps follow the plane memory: the cell index is registered at the accepting edge,
// the word is then read, and then it is written back and the result registered.
// Both planes share one memory of 512-bit words with a valid flag per word, so an advance
// clears a plane, and reset both, by the flags; no clearing pass runs after reset. The
// receiver cannot stall: it must take each response in the cycle done is high.
// Configuration writes are taken at any edge with cfg_we high and belong in idle time.
module two_plane_visited_bitmap_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  tpvb_pkg::request_t             request,
  output logic                           done,
  output tpvb_pkg::response_t            response,
  input  logic                           cfg_we,
  input  logic [tpvb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tpvb_pkg::CFG_W-1:0]     cfg_data
);
  import tpvb_pkg::*;

  ctrl_cmd_t cmd;

  tpvb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  tpvb_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .request   (request),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .response  (response)
  );

endmodule

### rtl/tpvb_chk.sv
// Port-level checker for the two-plane visited bitmap core, bound to the top level.
// Depends on tpvb_pkg for the payload types.
module tpvb_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           done,
  input tpvb_pkg::response_t            response
);
  import tpvb_pkg::*;

  // Each accepted request is answered by a done strobe.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("response did not follow an accepted request");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // The result strobe and busy never overlap: the block is free once it answers.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  a_processed_in_grid: assert property (@(posedge clk) disable iff (rst)
    done |-> !(response.processed && response.out_of_range))
    else $error("processed reported for an out-of-range cell");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!busy && !done))
    else $error("block not idle after reset");

endmodule

bind two_plane_visited_bitmap_core tpvb_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .response  (response)
);
